FILE: hw/rtl/sld_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
package sld_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PatternW = 24;
  localparam int unsigned LengthW  = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned RegIdxW  = 2;

  // Configuration register indexes
  localparam logic [RegIdxW-1:0] REG_START_PATTERN = 2'd0;
  localparam logic [RegIdxW-1:0] REG_END_PATTERN   = 2'd1;
  localparam logic [RegIdxW-1:0] REG_CHECK_SEED    = 2'd2;

  // Frame status codes
  localparam logic [StatusW-1:0] STATUS_GOOD      = 2'd0;
  localparam logic [StatusW-1:0] STATUS_CHECK_BAD = 2'd1;
  localparam logic [StatusW-1:0] STATUS_END_BAD   = 2'd2;

  typedef enum logic [7:0] {
    PH_HUNT    = 8'b0000_0001,
    PH_LEN_HI  = 8'b0000_0010,
    PH_LEN_LO  = 8'b0000_0100,
    PH_PAYLOAD = 8'b0000_1000,
    PH_CHECK   = 8'b0001_0000,
    PH_END0    = 8'b0010_0000,
    PH_END1    = 8'b0100_0000,
    PH_END2    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [PatternW-1:0] start_pattern;
    logic [PatternW-1:0] end_pattern;
    logic [ByteW-1:0]    check_seed;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic               is_payload;
    logic               frame_done;
    logic [StatusW-1:0] frame_status;
    logic [LengthW-1:0] frame_length;
  } result_t;

endpackage

FILE: hw/rtl/sld_parse.sv
// Frame parser: hunt window, header, payload check and end pattern compare.
module sld_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [sld_pkg::ByteW-1:0] rx_byte,
  input  sld_pkg::cfg_t          cfg,
  output logic                   emit,
  output sld_pkg::result_t       result
);
  import sld_pkg::*;

  phase_t             phase, phase_next;
  logic [LengthW-1:0] hunt_window, hunt_window_next;
  logic [1:0]         hunt_fill, hunt_fill_next;
  logic [LengthW-1:0] payload_length, payload_length_next;
  logic [LengthW-1:0] bytes_left, bytes_left_next;
  logic [ByteW-1:0]   running_check, running_check_next;
  logic               end_bad, end_bad_next;

  logic [PatternW-1:0] win;
  logic [LengthW-1:0]  len_full;
  logic [LengthW-1:0]  left_dec;
  logic                end_miss;

  assign win      = {hunt_window, rx_byte};
  assign len_full = {payload_length[LengthW-1:ByteW], rx_byte};
  assign left_dec = bytes_left - LengthW'(1);

  always_comb begin
    phase_next          = phase;
    hunt_window_next    = hunt_window;
    hunt_fill_next      = hunt_fill;
    payload_length_next = payload_length;
    bytes_left_next     = bytes_left;
    running_check_next  = running_check;
    end_bad_next        = end_bad;
    emit                = 1'b0;
    result              = '0;
    end_miss            = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (hunt_fill == 2'd2 && win == cfg.start_pattern) begin
          phase_next = PH_LEN_HI;
        end else begin
          hunt_window_next = win[LengthW-1:0];
          if (hunt_fill != 2'd2) hunt_fill_next = hunt_fill + 2'd1;
        end
      end
      PH_LEN_HI: begin
        payload_length_next = {rx_byte, {ByteW{1'b0}}};
        phase_next          = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_length_next = len_full;
        bytes_left_next     = len_full;
        running_check_next  = cfg.check_seed;
        end_bad_next        = 1'b0;
        phase_next          = (len_full == '0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        running_check_next = running_check ^ rx_byte;
        bytes_left_next    = left_dec;
        if (left_dec == '0) phase_next = PH_CHECK;
        emit              = 1'b1;
        result.out_byte   = rx_byte;
        result.is_payload = 1'b1;
      end
      PH_CHECK: begin
        if (rx_byte != running_check) begin
          emit                = 1'b1;
          result.frame_done   = 1'b1;
          result.frame_status = STATUS_CHECK_BAD;
          result.frame_length = payload_length;
          phase_next          = PH_HUNT;
          hunt_window_next    = '0;
          hunt_fill_next      = '0;
        end else begin
          phase_next = PH_END0;
        end
      end
      PH_END0: begin
        if (rx_byte != cfg.end_pattern[23:16]) end_bad_next = 1'b1;
        phase_next = PH_END1;
      end
      PH_END1: begin
        if (rx_byte != cfg.end_pattern[15:8]) end_bad_next = 1'b1;
        phase_next = PH_END2;
      end
      PH_END2: begin
        end_miss            = rx_byte != cfg.end_pattern[7:0];
        emit                = 1'b1;
        result.frame_done   = 1'b1;
        result.frame_status = (end_bad || end_miss) ? STATUS_END_BAD : STATUS_GOOD;
        result.frame_length = payload_length;
        phase_next          = PH_HUNT;
        hunt_window_next    = '0;
        hunt_fill_next      = '0;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      hunt_window    <= '0;
      hunt_fill      <= '0;
      payload_length <= '0;
      bytes_left     <= '0;
      running_check  <= '0;
      end_bad        <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      hunt_window    <= hunt_window_next;
      hunt_fill      <= hunt_fill_next;
      payload_length <= payload_length_next;
      bytes_left     <= bytes_left_next;
      running_check  <= running_check_next;
      end_bad        <= end_bad_next;
    end
  end

endmodule

FILE: hw/rtl/sld_out_reg.sv
// Result register on the output channel.
module sld_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  input  sld_pkg::result_t load_data,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_stall,
  output sld_pkg::result_t data
);
  import sld_pkg::*;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= load_valid;
    end
  end

  // hold the payload while the receiver stalls
  always_ff @(posedge clk) begin
    if (slot_free && load_valid) begin
      data <= load_data;
    end
  end

endmodule

FILE: hw/rtl/sync_length_xor_deframer.sv
// Top level of the length-prefixed frame deframer with XOR check byte.
//
// Input channel: one received byte per transfer on rx_byte, in_valid/in_stall.
// Output channel: out_valid/out_stall; each result is either a payload byte
// (is_payload) or a status item ending a frame attempt (frame_done with
// frame_status and frame_length), given by a bad check byte or the last end byte.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects start
// pattern (0), end pattern (1) or check seed (2); other indexes are ignored.
// cfg_ready is always high; write only while no frame byte is in flight.
//
// An accepted byte is held in the input register, the parser works on it and
// writes its result into the output register, from which it is offered. One
// byte per cycle is sustained while no result waits on a stalled receiver, set
// by the single parser step between the two registers.
// When the receiver stalls with a result waiting, the parser holds until the
// result register frees; bytes that give no result still pass. in_stall rises
// only when the input register cannot move on.
// Reset clears all configuration registers to zero, empties both registers
// and puts the parser back to hunting with an empty window.
module sync_length_xor_deframer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sld_pkg::ByteW-1:0]     rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sld_pkg::ByteW-1:0]     out_byte,
  output logic                          is_payload,
  output logic                          frame_done,
  output logic [sld_pkg::StatusW-1:0]   frame_status,
  output logic [sld_pkg::LengthW-1:0]   frame_length,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sld_pkg::RegIdxW-1:0]   cfg_index,
  input  logic [sld_pkg::PatternW-1:0]  cfg_data
);
  import sld_pkg::*;

  cfg_t             cfg;
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s1_advance;
  logic             emit;
  logic             slot_free;
  result_t          result;
  result_t          out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_PATTERN: cfg.start_pattern <= cfg_data;
        REG_END_PATTERN:   cfg.end_pattern   <= cfg_data;
        REG_CHECK_SEED:    cfg.check_seed    <= cfg_data[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // advance unless a result is due and the output register is full and stalled
  assign s1_advance = s1_valid && (!emit || slot_free);
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  sld_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_advance),
    .rx_byte (s1_byte),
    .cfg     (cfg),
    .emit    (emit),
    .result  (result)
  );

  sld_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s1_valid && emit),
    .load_data  (result),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data       (out_data)
  );

  assign out_byte     = out_data.out_byte;
  assign is_payload   = out_data.is_payload;
  assign frame_done   = out_data.frame_done;
  assign frame_status = out_data.frame_status;
  assign frame_length = out_data.frame_length;

endmodule
